### src/ir_pulse_train_encoder_top_macros.svh
// Assertion helpers shared by the encoder files.
// Both expect signals named clk and rst_n in the scope where they are used.
`ifndef IR_PULSE_TRAIN_ENCODER_TOP_MACROS_SVH
`define IR_PULSE_TRAIN_ENCODER_TOP_MACROS_SVH

// Same-cycle implication.
`define IRPTE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IRPTE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/irpte_pkg.sv
`timescale 1ns / 1ps
package irpte_pkg;

  localparam int unsigned MAX_BITS = 64;
  localparam int unsigned BITS_W   = 7;
  localparam int unsigned DUR_W    = 20;
  localparam int unsigned TIME_W   = 16;

  // Request codes on in_func.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_NEXT = 1'b1;

  // Coding modes; bit 1 selects level inversion.
  localparam logic [1:0] MODE_PULSE     = 2'd0;
  localparam logic [1:0] MODE_MANCH     = 2'd1;
  localparam logic [1:0] MODE_MANCH_INV = 2'd2;

  // Configuration register indexes.
  localparam logic [3:0] REG_PRE_MARK   = 4'd0;
  localparam logic [3:0] REG_PRE_SPACE  = 4'd1;
  localparam logic [3:0] REG_ONE_MARK   = 4'd2;
  localparam logic [3:0] REG_ONE_SPACE  = 4'd3;
  localparam logic [3:0] REG_ZERO_MARK  = 4'd4;
  localparam logic [3:0] REG_ZERO_SPACE = 4'd5;
  localparam logic [3:0] REG_SILENCE    = 4'd6;
  localparam logic [3:0] REG_MODE       = 4'd7;

  typedef enum logic [1:0] {
    PH_PRE  = 2'd0,
    PH_DATA = 2'd1,
    PH_SIL  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [TIME_W-1:0] pre_mark;
    logic [TIME_W-1:0] pre_space;
    logic [TIME_W-1:0] one_mark;
    logic [TIME_W-1:0] one_space;
    logic [TIME_W-1:0] zero_mark;
    logic [TIME_W-1:0] zero_space;
    logic [DUR_W-1:0]  silence;
    logic [1:0]        coding_mode;
  } cfg_t;

  typedef struct packed {
    phase_t              phase;
    logic [7:0]          timing_count;
    logic [BITS_W-1:0]   bits_sent;
    logic [MAX_BITS-1:0] msg;
    logic [BITS_W-1:0]   msg_len;
  } enc_state_t;

  typedef struct packed {
    logic [DUR_W-1:0] duration;
    logic             level;
    logic             status;
  } timing_t;

endpackage

### src/ir_pulse_train_encoder_top.sv
// IR pulse train encoder: one timing per request, loads produce no result.
// A FUNC_NEXT request writes its timing into the output register at the edge that accepts it.
// Throughput: one request per cycle while out_ready holds; the single output register frees in the cycle it is taken.
// The next-timing logic is one combinational pass from the state registers to that register.
// Reset (rst_n low at a clock edge) clears all configuration registers, the message and counters.
`timescale 1ns / 1ps
`include "ir_pulse_train_encoder_top_macros.svh"
module ir_pulse_train_encoder_top
  import irpte_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_func,
  input  logic [MAX_BITS-1:0] in_payload,
  input  logic [BITS_W-1:0]   in_bit_count,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [DUR_W-1:0]    out_duration,
  output logic                out_level,
  output logic                out_status,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [3:0]          cfg_index,
  input  logic [DUR_W-1:0]    cfg_data
);

  cfg_t       cfg_r, cfg_nxt;
  enc_state_t st_r, st_nxt, step_nxt;
  timing_t    step_res;
  timing_t    res_r;
  logic       out_valid_r, out_valid_nxt;
  logic       in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;

  irpte_step u_step (
    .cfg (cfg_r),
    .st  (st_r),
    .nxt (step_nxt),
    .res (step_res)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_PRE_MARK:   cfg_nxt.pre_mark    = cfg_data[TIME_W-1:0];
        REG_PRE_SPACE:  cfg_nxt.pre_space   = cfg_data[TIME_W-1:0];
        REG_ONE_MARK:   cfg_nxt.one_mark    = cfg_data[TIME_W-1:0];
        REG_ONE_SPACE:  cfg_nxt.one_space   = cfg_data[TIME_W-1:0];
        REG_ZERO_MARK:  cfg_nxt.zero_mark   = cfg_data[TIME_W-1:0];
        REG_ZERO_SPACE: cfg_nxt.zero_space  = cfg_data[TIME_W-1:0];
        REG_SILENCE:    cfg_nxt.silence     = cfg_data;
        REG_MODE:       cfg_nxt.coding_mode = cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (in_fire) begin
      if (in_func == FUNC_LOAD) begin
        st_nxt.msg          = in_payload;
        st_nxt.msg_len      = (in_bit_count > BITS_W'(MAX_BITS)) ? BITS_W'(MAX_BITS)
                                                                 : in_bit_count;
        st_nxt.phase        = PH_PRE;
        st_nxt.timing_count = '0;
        st_nxt.bits_sent    = '0;
      end else begin
        st_nxt        = step_nxt;
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '0;
      st_r        <= '{phase: PH_PRE, default: '0};
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_func == FUNC_NEXT) begin
      res_r <= step_res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_duration = res_r.duration;
  assign out_level    = res_r.level;
  assign out_status   = res_r.status;

  `IRPTE_ASSERT_NXT(a_load_no_result, in_fire && in_func == FUNC_LOAD, !out_valid, "load produced a timing")
  `IRPTE_ASSERT_NXT(a_next_result, in_fire && in_func == FUNC_NEXT, out_valid, "request lost its timing")
  `IRPTE_ASSERT_IMP(a_bits_bound, 1'b1, st_r.bits_sent <= st_r.msg_len && st_r.msg_len <= BITS_W'(MAX_BITS), "bit counter beyond message length")
  `IRPTE_ASSERT_IMP(a_pre_count, st_r.phase == PH_PRE, st_r.timing_count < 8'd2, "preamble phase with stale timing count")

endmodule

### src/irpte_step.sv
`timescale 1ns / 1ps
module irpte_step
  import irpte_pkg::*;
(
  input  cfg_t       cfg,
  input  enc_state_t st,
  output enc_state_t nxt,
  output timing_t    res
);

  logic              cur_bit;
  logic              odd;
  logic              done;
  logic              inv;
  logic [7:0]        tc_inc;
  logic [BITS_W-1:0] bs_inc;

  assign cur_bit = st.msg[st.bits_sent[5:0]];
  assign odd     = st.timing_count[0];
  assign done    = (st.bits_sent >= st.msg_len);
  assign inv     = cfg.coding_mode[1];
  assign tc_inc  = st.timing_count + 8'd1;
  assign bs_inc  = st.bits_sent + 7'd1;

  always_comb begin
    nxt = st;
    res = '0;
    case (st.phase)
      PH_PRE, PH_DATA: begin
        if (st.phase == PH_PRE && cfg.pre_mark != '0 && st.timing_count < 8'd2) begin
          if (st.timing_count == 8'd0) begin
            res.duration = DUR_W'(cfg.pre_mark);
            res.level    = 1'b1;
          end else begin
            res.duration = DUR_W'(cfg.pre_space);
            res.level    = 1'b0;
          end
          nxt.timing_count = tc_inc;
          nxt.phase        = (tc_inc >= 8'd2) ? PH_DATA : PH_PRE;
        end else if (cfg.coding_mode != MODE_PULSE) begin
          nxt.phase = PH_DATA;
          if (done) begin
            res.duration     = cfg.silence;
            res.status       = 1'b1;
            nxt.phase        = PH_PRE;
            nxt.timing_count = '0;
            nxt.bits_sent    = '0;
          end else begin
            res.duration     = DUR_W'(cfg.one_mark);
            res.level        = odd ^ cur_bit ^ inv;
            nxt.timing_count = tc_inc;
            if (odd) begin
              nxt.bits_sent = bs_inc;
              if (bs_inc >= st.msg_len) begin
                res.status = 1'b1;
                nxt.phase  = PH_SIL;
              end
            end
          end
        end else begin
          nxt.phase        = PH_DATA;
          nxt.timing_count = tc_inc;
          if (done) begin
            // Stop mark closes the data part.
            res.duration = DUR_W'(cfg.one_mark);
            res.level    = 1'b1;
            res.status   = 1'b1;
            nxt.phase    = PH_SIL;
          end else if (odd) begin
            res.duration  = DUR_W'(cur_bit ? cfg.one_space : cfg.zero_space);
            nxt.bits_sent = bs_inc;
          end else begin
            res.duration = DUR_W'(cur_bit ? cfg.one_mark : cfg.zero_mark);
            res.level    = 1'b1;
          end
        end
      end
      default: begin
        res.duration     = cfg.silence;
        res.status       = 1'b1;
        nxt.phase        = PH_PRE;
        nxt.timing_count = '0;
        nxt.bits_sent    = '0;
      end
    endcase
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
module tb
  import irpte_pkg::*;
;

  localparam int CLK_HALF   = 5;
  localparam int SETTLE     = 3;
  localparam int STALL_MAX  = 2000;
  localparam int BURST_SIZE = 20;

  typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

  typedef struct {
    row_kind_t           kind;
    logic                func;
    logic [MAX_BITS-1:0] payload;
    logic [BITS_W-1:0]   count;
    logic [3:0]          index;
    logic [DUR_W-1:0]    data;
    logic                fixed;
    timing_t             want;
  } script_row_t;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic                in_func      = FUNC_LOAD;
  logic [MAX_BITS-1:0] in_payload   = '0;
  logic [BITS_W-1:0]   in_bit_count = '0;
  logic                out_valid;
  logic                out_ready    = 1'b0;
  logic [DUR_W-1:0]    out_duration;
  logic                out_level;
  logic                out_status;
  logic                cfg_valid    = 1'b0;
  logic                cfg_ready;
  logic [3:0]          cfg_index    = REG_PRE_MARK;
  logic [DUR_W-1:0]    cfg_data     = '0;

  // Shadow of the encoder: its registers, its frame state and the timings owed.
  cfg_t        reg_file;
  enc_state_t  enc_now;
  timing_t     pending_timings[$];
  script_row_t script[$];

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int reqs_sent          = 0;
  int mismatches         = 0;
  int quiet_cycles       = 0;

  ir_pulse_train_encoder_top u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_payload   (in_payload),
    .in_bit_count (in_bit_count),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_duration (out_duration),
    .out_level    (out_level),
    .out_status   (out_status),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  function automatic void store_reg(input logic [3:0] idx, input logic [DUR_W-1:0] d);
    case (idx)
      REG_PRE_MARK:   reg_file.pre_mark    = d[TIME_W-1:0];
      REG_PRE_SPACE:  reg_file.pre_space   = d[TIME_W-1:0];
      REG_ONE_MARK:   reg_file.one_mark    = d[TIME_W-1:0];
      REG_ONE_SPACE:  reg_file.one_space   = d[TIME_W-1:0];
      REG_ZERO_MARK:  reg_file.zero_mark   = d[TIME_W-1:0];
      REG_ZERO_SPACE: reg_file.zero_space  = d[TIME_W-1:0];
      REG_SILENCE:    reg_file.silence     = d;
      REG_MODE:       reg_file.coding_mode = d[1:0];
      default: ;
    endcase
  endfunction

  function automatic void close_frame(output timing_t t);
    t = {reg_file.silence, 1'b0, 1'b1};
    enc_now.phase        = PH_PRE;
    enc_now.timing_count = '0;
    enc_now.bits_sent    = '0;
  endfunction

  // Returns 1 when the request yields a timing, which is placed in t.
  function automatic logic next_timing(input logic f, input logic [MAX_BITS-1:0] p,
                                       input logic [BITS_W-1:0] n, output timing_t t);
    logic odd;
    logic cur;
    t = '0;
    if (f == FUNC_LOAD) begin
      enc_now.msg          = p;
      enc_now.msg_len      = (n > MAX_BITS) ? BITS_W'(MAX_BITS) : n;
      enc_now.phase        = PH_PRE;
      enc_now.timing_count = '0;
      enc_now.bits_sent    = '0;
      return 1'b0;
    end
    if (enc_now.phase == PH_PRE) begin
      if (reg_file.pre_mark != '0 && enc_now.timing_count < 8'd2) begin
        if (enc_now.timing_count == 8'd0) begin
          t = {DUR_W'(reg_file.pre_mark), 1'b1, 1'b0};
        end else begin
          t = {DUR_W'(reg_file.pre_space), 1'b0, 1'b0};
        end
        enc_now.timing_count = enc_now.timing_count + 8'd1;
        if (enc_now.timing_count >= 8'd2) enc_now.phase = PH_DATA;
        return 1'b1;
      end
      // With no preamble the same request goes on into the data part.
      enc_now.phase = PH_DATA;
    end
    if (enc_now.phase == PH_DATA) begin
      odd = enc_now.timing_count[0];
      cur = enc_now.msg[enc_now.bits_sent[5:0]];
      if (reg_file.coding_mode != MODE_PULSE) begin
        if (enc_now.bits_sent >= enc_now.msg_len) begin
          close_frame(t);
          return 1'b1;
        end
        t = {DUR_W'(reg_file.one_mark), odd ^ cur ^ reg_file.coding_mode[1], 1'b0};
        if (odd) begin
          enc_now.bits_sent = enc_now.bits_sent + 1'b1;
          if (enc_now.bits_sent >= enc_now.msg_len) begin
            t.status      = 1'b1;
            enc_now.phase = PH_SIL;
          end
        end
        enc_now.timing_count = enc_now.timing_count + 8'd1;
        return 1'b1;
      end
      if (enc_now.bits_sent >= enc_now.msg_len) begin
        t = {DUR_W'(reg_file.one_mark), 1'b1, 1'b1};
        enc_now.timing_count = enc_now.timing_count + 8'd1;
        enc_now.phase        = PH_SIL;
        return 1'b1;
      end
      if (odd) begin
        t = {DUR_W'(cur ? reg_file.one_space : reg_file.zero_space), 1'b0, 1'b0};
        enc_now.bits_sent = enc_now.bits_sent + 1'b1;
      end else begin
        t = {DUR_W'(cur ? reg_file.one_mark : reg_file.zero_mark), 1'b1, 1'b0};
      end
      enc_now.timing_count = enc_now.timing_count + 8'd1;
      return 1'b1;
    end
    close_frame(t);
    return 1'b1;
  endfunction

  function automatic void add_req(input logic f, input logic [MAX_BITS-1:0] p,
                                  input logic [BITS_W-1:0] n, input logic fixed,
                                  input timing_t want);
    script_row_t r;
    r.kind    = ROW_REQ;
    r.func    = f;
    r.payload = p;
    r.count   = n;
    r.index   = REG_PRE_MARK;
    r.data    = '0;
    r.fixed   = fixed;
    r.want    = want;
    script.push_back(r);
  endfunction

  function automatic void add_cfg(input logic [3:0] idx, input logic [DUR_W-1:0] d);
    script_row_t r;
    r.kind    = ROW_CFG;
    r.func    = FUNC_LOAD;
    r.payload = '0;
    r.count   = '0;
    r.index   = idx;
    r.data    = d;
    r.fixed   = 1'b0;
    r.want    = '0;
    script.push_back(r);
  endfunction

  // Called at a falling edge; returns at a falling edge with in_valid still high.
  task automatic send_req(input logic f, input logic [MAX_BITS-1:0] p,
                          input logic [BITS_W-1:0] n, input logic fixed, input timing_t want);
    timing_t t;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= f;
    in_payload   <= p;
    in_bit_count <= n;
    do @(posedge clk); while (!in_ready);
    if (next_timing(f, p, n, t)) pending_timings.push_back(fixed ? want : t);
    reqs_sent++;
    @(negedge clk);
  endtask

  task automatic pause_sender(input int settle);
    in_valid <= 1'b0;
    while (pending_timings.size() != 0) @(negedge clk);
    repeat (settle + 1) @(negedge clk);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [DUR_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    store_reg(idx, d);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [DUR_W-1:0] pick_reg_value();
    int r;
    r = $urandom_range(99);
    if (r < 20) return '0;
    if (r < 40) return '1;
    return DUR_W'($urandom);
  endfunction

  task automatic shuffle_config();
    write_reg(REG_PRE_MARK,   pick_reg_value());
    write_reg(REG_PRE_SPACE,  pick_reg_value());
    write_reg(REG_ONE_MARK,   pick_reg_value());
    write_reg(REG_ONE_SPACE,  pick_reg_value());
    write_reg(REG_ZERO_MARK,  pick_reg_value());
    write_reg(REG_ZERO_SPACE, pick_reg_value());
    write_reg(REG_SILENCE,    pick_reg_value());
    write_reg(REG_MODE,       pick_reg_value());
  endtask

  // Mostly a load followed by enough requests to play the whole frame; some
  // frames are cut short by the next load, and a few requests are pure noise.
  task automatic run_random_burst(input int quota);
    int start;
    int n;
    int r;
    int frame_len;
    start = reqs_sent;
    while (reqs_sent - start < quota) begin
      if ($urandom_range(99) < 10) begin
        send_req(1'($urandom_range(1)), {$urandom, $urandom}, BITS_W'($urandom), 1'b0, '0);
      end else begin
        r = $urandom_range(99);
        if (r < 75) n = $urandom_range(8);
        else if (r < 92) n = $urandom_range(40, 9);
        else n = $urandom_range(127, 41);
        send_req(FUNC_LOAD, {$urandom, $urandom}, BITS_W'(n), 1'b0, '0);
        frame_len = 2 * ((n > MAX_BITS) ? MAX_BITS : n) + 4 + $urandom_range(3);
        if ($urandom_range(99) < 20) frame_len = $urandom_range(frame_len);
        repeat (frame_len) begin
          send_req(FUNC_NEXT, {$urandom, $urandom}, BITS_W'($urandom), 1'b0, '0);
        end
      end
      if ($urandom_range(99) < 3) pause_sender(0);
    end
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin : check_timing
    timing_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_timings.size() == 0) begin
        $error("unexpected timing: duration %0h level %0b status %0b",
               out_duration, out_level, out_status);
        mismatches++;
      end else begin
        want = pending_timings.pop_front();
        if (out_duration !== want.duration) begin
          $error("duration: expected %0h, actual %0h", want.duration, out_duration);
          mismatches++;
        end
        if (out_level !== want.level) begin
          $error("level: expected %0b, actual %0b", want.level, out_level);
          mismatches++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0b, actual %0b", want.status, out_status);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_MAX) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int idle_pcts[4];
    int stall_pcts[4];
    idle_pcts  = '{0, 53, 0, 25};
    stall_pcts = '{0, 0, 53, 25};
    reg_file = '0;
    enc_now  = '0;
    enc_now.phase = PH_PRE;

    // Straight after reset every register is zero, so an empty pulse-coded
    // message gives a zero-length stop mark and then a zero silence.
    add_req(FUNC_NEXT, '0, '0, 1'b1, {20'h00000, 1'b1, 1'b1});
    add_req(FUNC_NEXT, '0, '0, 1'b1, {20'h00000, 1'b0, 1'b1});
    add_cfg(REG_PRE_MARK,   20'hFFFFF);
    add_cfg(REG_PRE_SPACE,  20'h00001);
    add_cfg(REG_ONE_MARK,   20'h00230);
    add_cfg(REG_ONE_SPACE,  20'h00690);
    add_cfg(REG_ZERO_MARK,  20'h00231);
    add_cfg(REG_ZERO_SPACE, 20'h00232);
    add_cfg(REG_SILENCE,    20'hFFFFF);
    add_cfg(REG_MODE,       DUR_W'(MODE_PULSE));
    add_req(FUNC_LOAD, 64'hFFFF_FFFF_FFFF_FFFD, 7'd2, 1'b0, '0);
    add_req(FUNC_NEXT, '0, '0, 1'b1, {20'h0FFFF, 1'b1, 1'b0});
    add_req(FUNC_NEXT, '0, '0, 1'b1, {20'h00001, 1'b0, 1'b0});
    repeat (5) add_req(FUNC_NEXT, '1, '1, 1'b0, '0);
    add_req(FUNC_NEXT, '0, '0, 1'b1, {20'hFFFFF, 1'b0, 1'b1});
    add_req(FUNC_NEXT, '0, '0, 1'b1, {20'h0FFFF, 1'b1, 1'b0});
    // A zero preamble mark falls straight through; an empty Manchester
    // message then ends in the silence at once.
    add_cfg(REG_PRE_MARK, 20'h00000);
    add_cfg(REG_MODE,     DUR_W'(MODE_MANCH_INV));
    add_req(FUNC_LOAD, '0, 7'd0, 1'b0, '0);
    add_req(FUNC_NEXT, '0, '0, 1'b1, {20'hFFFFF, 1'b0, 1'b1});
    add_cfg(REG_MODE, DUR_W'(MODE_MANCH | MODE_MANCH_INV));
    add_req(FUNC_LOAD, 64'h8000_0000_0000_0000, 7'h7F, 1'b0, '0);
    repeat (2) add_req(FUNC_NEXT, '0, '0, 1'b0, '0);
    add_req(FUNC_LOAD, 64'h1, 7'd1, 1'b0, '0);
    repeat (3) add_req(FUNC_NEXT, '0, '0, 1'b0, '0);
    add_cfg(REG_MODE, DUR_W'(MODE_MANCH));
    add_req(FUNC_LOAD, '0, 7'd1, 1'b0, '0);
    repeat (3) add_req(FUNC_NEXT, '0, '0, 1'b0, '0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        pause_sender(SETTLE);
        write_reg(script[i].index, script[i].data);
      end else begin
        send_req(script[i].func, script[i].payload, script[i].count,
                 script[i].fixed, script[i].want);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct    = idle_pcts[ph];
      receiver_stall_pct = stall_pcts[ph];
      repeat (3) begin
        pause_sender(SETTLE);
        shuffle_config();
        run_random_burst(BURST_SIZE);
      end
    end

    in_valid <= 1'b0;
    while (pending_timings.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
